@@ rtl/tprs_pkg.sv @@
// ----------------------------------------------------------------------------
// tprs_pkg: shared constants for the timer prescaler / reload search
// Field widths, the reset clock rate and the width of the count that the
// divider works on.
// ----------------------------------------------------------------------------
package tprs_pkg;

   localparam int TIMER_RANGE_DEF = 65536;

   localparam int PERIOD_W = 32;
   localparam int MHZ_W    = 10;
   localparam int FIELD_W  = 16;

   // Width of the full product of period and clock rate, and of the largest legal count (2^32).
   localparam int PROD_W  = PERIOD_W + MHZ_W;
   localparam int COUNT_W = 33;

   localparam logic [MHZ_W-1:0] MHZ_RESET = 10'd72;

endpackage

@@ rtl/tprs_div.sv @@
// ----------------------------------------------------------------------------
// tprs_div: restoring divider, one quotient bit per cycle
// Divides the count by the trial divisor. The dividend shifts out of the
// top of a shift register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module tprs_div import tprs_pkg::*; #(
   parameter int DIV_W = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               div_start,
   input  logic [COUNT_W-1:0] div_dividend,
   input  logic [DIV_W-1:0]   div_divisor,
   output logic               div_done,
   output logic [COUNT_W-1:0] div_quotient,
   output logic [DIV_W-1:0]   div_remainder
);

   localparam int STEP_W = $clog2(COUNT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] qr_ff, qr_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_W:0]     trial;
   logic               fits;

   assign trial = {rem_ff, qr_ff[COUNT_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      qr_in   = qr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         busy_in = 1'b1;
         step_in = '0;
         qr_in   = div_dividend;
         rem_in  = '0;
         dvs_in  = div_divisor;
      end else if (busy_ff) begin
         qr_in = {qr_ff[COUNT_W-2:0], fits};
         // The partial remainder stays below the divisor, so it fits DIV_W bits.
         if (fits) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      qr_ff   <= qr_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_done      = done_ff;
   assign div_quotient  = qr_ff;
   assign div_remainder = rem_ff;

endmodule

@@ rtl/timer_prescaler_reload_search_top.sv @@
// ----------------------------------------------------------------------------
// timer_prescaler_reload_search_top: prescaler and auto-reload search
// Splits a period in microseconds into prescaler-1 and reload-1 for a timer
// clocked at csr_counter_mhz.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is produced, and the result appears on the rsp_ ports for
// exactly one cycle with rsp_valid high, so the receiver must take it then.
// The count period_us * counter_mhz is formed by a bit-serial shift-add over
// the clock-rate bits. A count of zero or above 2^32 gives an error result
// from the check that follows the multiply. Otherwise every trial divisor from
// 1 up to TIMER_RANGE goes through a restoring divider that makes one quotient
// bit per cycle; the search ends early at the first divisor that splits the
// count exactly with a quotient that fits. The product d*q is never formed:
// the largest product is the smallest remainder among divisors whose
// quotient fits.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_search_top import tprs_pkg::*; #(
   parameter int TIMER_RANGE = TIMER_RANGE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [PERIOD_W-1:0] req_period_us,
   output logic                rsp_valid,
   output logic                rsp_period_error,
   output logic [FIELD_W-1:0]  rsp_prescaler_minus_one,
   output logic [FIELD_W-1:0]  rsp_reload_minus_one,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MHZ_W-1:0]    csr_counter_mhz
);

   localparam int DIV_W = $clog2(TIMER_RANGE + 1);
   localparam int MUL_W = $clog2(MHZ_W);
   localparam logic [DIV_W-1:0]   RANGE_D   = DIV_W'(TIMER_RANGE);
   localparam logic [COUNT_W-1:0] RANGE_Q   = COUNT_W'(TIMER_RANGE);
   localparam logic [MUL_W-1:0]   LAST_MBIT = MUL_W'(MHZ_W - 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_MUL    = 5'b00010,
      S_CHECK  = 5'b00100,
      S_DIV    = 5'b01000,
      S_REPORT = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [MHZ_W-1:0]    mhz_ff;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [MHZ_W-1:0]    mhz_sh_ff, mhz_sh_in;
   logic [MUL_W-1:0]    mul_ctr_ff, mul_ctr_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [DIV_W-1:0]    trial_ff, trial_in;
   logic                found_ff, found_in;
   logic [DIV_W-1:0]    best_rem_ff, best_rem_in;
   logic [DIV_W-1:0]    best_d_ff, best_d_in;
   logic [DIV_W-1:0]    best_q_ff, best_q_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_error_ff, rsp_error_in;
   logic [FIELD_W-1:0]  rsp_presc_ff, rsp_presc_in;
   logic [FIELD_W-1:0]  rsp_reload_ff, rsp_reload_in;

   logic                div_start;
   logic                div_done;
   logic [COUNT_W-1:0]  div_quotient;
   logic [DIV_W-1:0]    div_remainder;

   logic count_zero, count_big;
   logic q_ok, take;

   assign count_zero = acc_ff == '0;
   assign count_big  = (|acc_ff[PROD_W-1:COUNT_W]) ||
                       (acc_ff[COUNT_W-1] && (|acc_ff[COUNT_W-2:0]));

   // A zero quotient gives a zero product, which never beats the start value.
   assign q_ok = (div_quotient != '0) && (div_quotient <= RANGE_Q);
   assign take = q_ok && (!found_ff || (div_remainder < best_rem_ff));

   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      mhz_sh_in     = mhz_sh_ff;
      mul_ctr_in    = mul_ctr_ff;
      acc_in        = acc_ff;
      trial_in      = trial_ff;
      found_in      = found_ff;
      best_rem_in   = best_rem_ff;
      best_d_in     = best_d_ff;
      best_q_in     = best_q_ff;
      rsp_valid_in  = 1'b0;
      rsp_error_in  = rsp_error_ff;
      rsp_presc_in  = rsp_presc_ff;
      rsp_reload_in = rsp_reload_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               period_in  = req_period_us;
               mhz_sh_in  = mhz_ff;
               mul_ctr_in = '0;
               acc_in     = '0;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            // Most significant clock-rate bit first: double, then add.
            acc_in = (acc_ff << 1) +
                     (mhz_sh_ff[MHZ_W-1] ? PROD_W'(period_ff) : PROD_W'(0));
            mhz_sh_in  = mhz_sh_ff << 1;
            mul_ctr_in = mul_ctr_ff + 1'b1;
            if (mul_ctr_ff == LAST_MBIT) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (count_zero || count_big) begin
               rsp_valid_in  = 1'b1;
               rsp_error_in  = 1'b1;
               rsp_presc_in  = '0;
               rsp_reload_in = '0;
               state_in      = S_IDLE;
            end else begin
               found_in  = 1'b0;
               trial_in  = DIV_W'(1);
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (take) begin
                  found_in    = 1'b1;
                  best_rem_in = div_remainder;
                  best_d_in   = trial_ff;
                  best_q_in   = div_quotient[DIV_W-1:0];
               end
               // An exact split cannot be beaten by any later divisor.
               if ((take && (div_remainder == '0)) || (trial_ff == RANGE_D)) begin
                  state_in = S_REPORT;
               end else begin
                  trial_in  = trial_ff + 1'b1;
                  div_start = 1'b1;
               end
            end
         end
         S_REPORT: begin
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               rsp_error_in  = 1'b0;
               rsp_presc_in  = FIELD_W'(best_d_ff - 1'b1);
               rsp_reload_in = FIELD_W'(best_q_ff - 1'b1);
            end else begin
               rsp_error_in  = 1'b1;
               rsp_presc_in  = '0;
               rsp_reload_in = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mhz_ff       <= MHZ_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mhz_ff <= csr_counter_mhz;
         end
      end
      period_ff     <= period_in;
      mhz_sh_ff     <= mhz_sh_in;
      mul_ctr_ff    <= mul_ctr_in;
      acc_ff        <= acc_in;
      trial_ff      <= trial_in;
      found_ff      <= found_in;
      best_rem_ff   <= best_rem_in;
      best_d_ff     <= best_d_in;
      best_q_ff     <= best_q_in;
      rsp_error_ff  <= rsp_error_in;
      rsp_presc_ff  <= rsp_presc_in;
      rsp_reload_ff <= rsp_reload_in;
   end

   tprs_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (acc_ff[COUNT_W-1:0]),
      .div_divisor  (trial_in),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .div_remainder(div_remainder)
   );

   assign busy                    = state_ff != S_IDLE;
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_period_error        = rsp_error_ff;
   assign rsp_prescaler_minus_one = rsp_presc_ff;
   assign rsp_reload_minus_one    = rsp_reload_ff;

`ifndef ASSERT_OFF
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_CHECK || $past(state_ff) == S_REPORT))
      else $error("result strobe without a finished search");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_presc_ff == '0 && rsp_reload_ff == '0))
      else $error("error result carries nonzero fields");

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the search");

   a_found_quotient: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPORT && found_ff) |-> (best_q_ff != '0 && best_d_ff != '0))
      else $error("best split holds a zero divisor or quotient");
`endif

endmodule

@@ bench/tb_timer_prescaler_reload_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_prescaler_reload_search_top: prescaler / reload search testbench
// Sends interrupt periods to the search block under several counter clock
// rates and checks every prescaler / reload split against a local predictor.
// Random periods are kept to ones whose search ends early, so the run stays
// short; one directed item covers the largest legal count.
// ----------------------------------------------------------------------------
module tb_timer_prescaler_reload_search_top;
   import tprs_pkg::*;

   typedef struct packed {
      logic               err;
      logic [FIELD_W-1:0] presc;
      logic [FIELD_W-1:0] reload;
   } period_split_type;

   localparam logic [PROD_W-1:0] COUNT_LIMIT = 42'h1_0000_0000;
   localparam int unsigned SEARCH_BUDGET = 1024;
   localparam int unsigned DRAIN_CYCLES  = 40;
   // Slowest item: every divisor through a full divide, taken three times over.
   localparam int unsigned STALL_LIMIT   = 3 * (34 * TIMER_RANGE_DEF + 13) + 200;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [PERIOD_W-1:0] req_period_us;
   logic                rsp_valid;
   logic                rsp_period_error;
   logic [FIELD_W-1:0]  rsp_prescaler_minus_one;
   logic [FIELD_W-1:0]  rsp_reload_minus_one;
   logic                csr_valid;
   logic                csr_ready;
   logic [MHZ_W-1:0]    csr_counter_mhz;

   period_split_type    expected_splits[$];
   logic [MHZ_W-1:0]    rate_mhz;
   int unsigned         mismatches;
   int unsigned         quiet_cycles;
   period_split_type    rsp_seen;
   period_split_type    rsp_due;

   timer_prescaler_reload_search_top i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_period_us           (req_period_us),
      .rsp_valid               (rsp_valid),
      .rsp_period_error        (rsp_period_error),
      .rsp_prescaler_minus_one (rsp_prescaler_minus_one),
      .rsp_reload_minus_one    (rsp_reload_minus_one),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_counter_mhz         (csr_counter_mhz)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Splits period * mhz into divisor and quotient, searching divisors up to
   // max_div. Returns the divisor at which the search stopped on a second
   // exact split, max_div + 1 if it ran out, or 0 for an out-of-range count.
   function automatic int unsigned split_period(input logic [PERIOD_W-1:0] period,
                                                input logic [MHZ_W-1:0] mhz,
                                                input int unsigned max_div,
                                                output period_split_type res);
      logic [PROD_W-1:0] count;
      logic [PROD_W-1:0] quot;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] best_prod;
      logic [16:0]       best_div;
      logic [16:0]       best_quot;
      logic              done;
      int unsigned       d;
      int unsigned       stop_at;
      count = PROD_W'(period) * PROD_W'(mhz);
      res = '0;
      res.err = 1'b1;
      if (count == '0 || count > COUNT_LIMIT) begin
         return 0;
      end
      best_prod = '0;
      best_div  = '0;
      best_quot = '0;
      done      = 1'b0;
      stop_at   = max_div + 1;
      for (d = 1; d <= max_div && !done; d++) begin
         quot = count / PROD_W'(d);
         if (quot <= PROD_W'(TIMER_RANGE_DEF)) begin
            prod = PROD_W'(d) * quot;
            if (prod > best_prod) begin
               best_prod = prod;
               best_div  = 17'(d);
               best_quot = 17'(quot);
            end else if (prod == count) begin
               done    = 1'b1;
               stop_at = d;
            end
         end
      end
      if (best_div != '0 && best_quot != '0) begin
         res.err    = 1'b0;
         res.presc  = 16'(best_div - 17'd1);
         res.reload = 16'(best_quot - 17'd1);
      end
      return stop_at;
   endfunction

   task automatic report_mismatch(input string what, input period_split_type want,
                                  input period_split_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected err=%0b presc=%0d reload=%0d, got err=%0b presc=%0d reload=%0d",
                  what, want.err, want.presc, want.reload, got.err, got.presc, got.reload);
      end
   endtask

   task automatic drain_results();
      do @(posedge clock); while (expected_splits.size() != 0);
   endtask

   task automatic send_period(input logic [PERIOD_W-1:0] period);
      int unsigned      roll;
      int unsigned      gap;
      period_split_type want;
      roll = $urandom_range(0, 99);
      gap  = (roll < 50) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      @(posedge clock);
      repeat (gap) @(posedge clock);
      start         <= 1'b1;
      req_period_us <= period;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      void'(split_period(period, rate_mhz, TIMER_RANGE_DEF, want));
      expected_splits.push_back(want);
   endtask

   task automatic set_counter_mhz(input logic [MHZ_W-1:0] mhz);
      drain_results();
      csr_valid       <= 1'b1;
      csr_counter_mhz <= mhz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rate_mhz = mhz;
   endtask

   // Runs at the reset rate of 72 MHz, without any register write.
   task automatic test_reset_rate();
      send_period(32'd0);
      send_period(32'hFFFF_FFFF);
      send_period(32'd1);
      send_period(32'd3);
      send_period(32'd910);
      send_period(32'd911);
      send_period(32'd59652324);
      send_period(32'h5555_5555);
      send_period(32'hAAAA_AAAA);
   endtask

   task automatic test_rate_extremes();
      set_counter_mhz(10'd1);
      send_period(32'd0);
      send_period(32'd2);
      send_period(32'd65536);
      send_period(32'd65538);
      set_counter_mhz(10'd1023);
      send_period(32'd1);
      send_period(32'd4198405);
      send_period(32'hFFFF_FFFF);
      // A zero rate makes every count zero.
      set_counter_mhz(10'd0);
      send_period(32'h1234_5678);
      send_period(32'd0);
   endtask

   // A count of exactly 2^32 is still legal and needs the widest split.
   task automatic test_count_limit();
      set_counter_mhz(10'd512);
      send_period(32'h0080_0000);
      send_period(32'h0080_0001);
   endtask

   task automatic test_random_periods(input logic [MHZ_W-1:0] mhz, input int unsigned items);
      int unsigned         kind;
      int unsigned         stop;
      logic [PERIOD_W-1:0] period;
      period_split_type    trial;
      set_counter_mhz(mhz);
      repeat (items) begin
         // Most periods are small values with power-of-two factors, so the
         // search hits two exact splits early; noise mostly gives errors.
         do begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
               period = $urandom;
            end else if (kind == 2) begin
               period = $urandom_range(0, 4096);
            end else begin
               period = $urandom_range(1, 2047) << $urandom_range(0, 16);
            end
            stop = split_period(period, mhz, SEARCH_BUDGET, trial);
         end while (stop > SEARCH_BUDGET || (kind > 2 && trial.err));
         if ($urandom_range(0, 9) == 0) begin
            drain_results();
         end
         send_period(period);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_seen = {rsp_period_error, rsp_prescaler_minus_one, rsp_reload_minus_one};
         if (expected_splits.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_seen);
         end else begin
            rsp_due = expected_splits.pop_front();
            if (rsp_seen.err !== rsp_due.err || rsp_seen.presc !== rsp_due.presc ||
                rsp_seen.reload !== rsp_due.reload) begin
               report_mismatch("wrong result", rsp_due, rsp_seen);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[timer_prescaler_reload_search_top] ERROR");
         $finish;
      end
   end

   initial begin
      mismatches      = 0;
      quiet_cycles    = 0;
      rate_mhz        = MHZ_RESET;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_period_us   <= '0;
      csr_valid       <= 1'b0;
      csr_counter_mhz <= MHZ_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_rate();
      test_rate_extremes();
      test_count_limit();
      test_random_periods(10'd1000, 20);
      test_random_periods(10'd1, 20);
      test_random_periods(10'($urandom_range(2, 1022)), 20);
      test_random_periods(10'd1023, 20);
      test_random_periods(MHZ_RESET, 20);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[timer_prescaler_reload_search_top] OK");
      end else begin
         $display("[timer_prescaler_reload_search_top] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tprs_pkg.sv
rtl/tprs_div.sv
rtl/timer_prescaler_reload_search_top.sv
bench/tb_timer_prescaler_reload_search_top.sv
